// ----- hw/rtl/crl_pkg.sv -----
package crl_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 17;
  localparam int NP_W  = 7;
  localparam int IDX_W = 6;
  localparam int FRAC_W = 16;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // 1.0 in Q1.16
  localparam logic [POS_W-1:0] FRAC_ONE = 17'h10000;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef value_t point_set_t [4];

endpackage

// ----- hw/rtl/crl_table.sv -----
module crl_table #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  crl_pkg::value_t     wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output crl_pkg::value_t     rd_data
);
  import crl_pkg::*;

  value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/crl_eval.sv -----
module crl_eval (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [crl_pkg::POS_W-1:0]  frac,
  input  crl_pkg::point_set_t        pts,
  output logic                       done,
  output crl_pkg::value_t            result
);
  import crl_pkg::*;

  localparam int COEF_W = 36;
  localparam int ACC_W  = 38;
  localparam int PROD_W = ACC_W + POS_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic signed [SUM_W-1:0] RND16 = SUM_W'(1) << (FRAC_W - 1);
  localparam logic signed [SUM_W-1:0] RND17 = SUM_W'(1) << FRAC_W;
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_MUL  = 4'b0010,
    E_ADD  = 4'b0100,
    E_SAT  = 4'b1000
  } estate_t;

  estate_t                    state;
  logic [1:0]                 pass;
  logic [POS_W-1:0]           t;
  logic signed [COEF_W-1:0]   coef_b;
  logic signed [COEF_W-1:0]   coef_c;
  logic signed [COEF_W-1:0]   coef_d;
  logic signed [ACC_W-1:0]    acc;
  logic signed [PROD_W-1:0]   prod;

  logic signed [COEF_W-1:0]   e0, e1, e2, e3;
  logic signed [COEF_W-1:0]   a_next, b_next, c_next, d_next;
  logic signed [PROD_W-1:0]   mul_out;
  logic signed [COEF_W-1:0]   k_sel;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    shifted;
  logic                       last_pass;

  assign e0 = COEF_W'(pts[0]);
  assign e1 = COEF_W'(pts[1]);
  assign e2 = COEF_W'(pts[2]);
  assign e3 = COEF_W'(pts[3]);

  assign a_next = (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
  assign b_next = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign c_next = e2 - e0;
  assign d_next = e1 <<< 1;

  assign mul_out = acc * $signed({1'b0, t});

  assign last_pass = (pass == 2'd2);

  always_comb begin
    case (pass)
      2'd0:    k_sel = coef_b;
      2'd1:    k_sel = coef_c;
      default: k_sel = coef_d;
    endcase
  end

  // round half up, then floor shift
  assign sum = SUM_W'(prod) + (SUM_W'(k_sel) <<< FRAC_W) + (last_pass ? RND17 : RND16);
  assign shifted = last_pass ? (sum >>> (FRAC_W + 1)) : (sum >>> FRAC_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      pass  <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        E_IDLE: begin
          if (start) begin
            pass  <= 2'd0;
            state <= E_MUL;
          end
        end
        E_MUL: begin
          state <= E_ADD;
        end
        E_ADD: begin
          if (last_pass) begin
            state <= E_SAT;
          end else begin
            pass  <= pass + 2'd1;
            state <= E_MUL;
          end
        end
        E_SAT: begin
          done  <= 1'b1;
          state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      E_IDLE: begin
        if (start) begin
          t      <= frac;
          acc    <= ACC_W'(a_next);
          coef_b <= b_next;
          coef_c <= c_next;
          coef_d <= d_next;
        end
      end
      E_MUL: prod <= mul_out;
      E_ADD: acc <= ACC_W'(shifted);
      E_SAT: begin
        if (acc > SAT_HI) begin
          result <= value_t'(SAT_HI[VAL_W-1:0]);
        end else if (acc < SAT_LO) begin
          result <= value_t'(SAT_LO[VAL_W-1:0]);
        end else begin
          result <= acc[VAL_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/catmull_rom_curve_lookup.sv -----
// Channel  | Handshake                  | Word
// ---------+----------------------------+--------------------------------------------
// item     | item_valid / item_ready    | req_type, point_index, point_value, position
// result   | result_valid / result_ready| curve_value
// config   | cfg_write_en (no wait)     | cfg_write_data -> num_points
//
// Between accepting a query and taking the next word, the block makes four reads
// through the single read port of the point table and three multiply/round passes
// through one shared multiplier. A query with fewer than two points goes straight
// to output with a zero result.
// rst is synchronous: it clears the sequencer, num_points and result_valid; the
// table is not cleared. A held result stalls the next query and all items after it.
module catmull_rom_curve_lookup #(
  parameter int MAX_POINTS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic                        req_type,
  input  logic [crl_pkg::IDX_W-1:0]   point_index,
  input  crl_pkg::value_t             point_value,
  input  logic [crl_pkg::POS_W-1:0]   position,
  output logic                        result_valid,
  input  logic                        result_ready,
  output crl_pkg::value_t             curve_value,
  input  logic                        cfg_write_en,
  input  logic [crl_pkg::NP_W-1:0]    cfg_write_data
);
  import crl_pkg::*;

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SCL_W = POS_W + NP_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SEG   = 6'b000010,
    S_READ  = 6'b000100,
    S_START = 6'b001000,
    S_WAIT  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t              state;
  logic [NP_W-1:0]     num_points;
  logic [SCL_W-1:0]    scaled;
  logic [NP_W-1:0]     seg;
  logic [POS_W-1:0]    frac;
  logic [2:0]          cnt;
  logic                zero_res;
  value_t              pts [4];

  logic                accept;
  logic [NP_W-1:0]     n_eff, n_m1, n_m2;
  logic [POS_W-1:0]    pos_c;
  logic [SCL_W-1:0]    scaled_next;
  logic [7:0]          seg_hi;
  logic [NP_W-1:0]     rd_addr7;
  logic [2:0]          cnt_m1;
  logic                out_free;
  logic                wr_en, rd_en;
  logic [AW+IDX_W-1:0] wr_wide;
  logic [AW+NP_W-1:0]  rd_wide;
  value_t              rd_data;
  logic                eval_start, eval_done;
  value_t              eval_result;

  assign accept     = item_valid && item_ready;
  assign item_ready = (state == S_IDLE);

  assign n_eff = (32'(num_points) > MAX_POINTS) ? NP_W'(MAX_POINTS) : num_points;
  assign n_m1  = n_eff - NP_W'(1);
  assign n_m2  = n_eff - NP_W'(2);

  assign pos_c       = (position > FRAC_ONE) ? FRAC_ONE : position;
  assign scaled_next = SCL_W'(pos_c) * SCL_W'(n_m1);
  assign seg_hi      = scaled[SCL_W-1:FRAC_W];

  // neighbor order: left, seg, right, far right; ends borrow the inner point
  always_comb begin
    case (cnt[1:0])
      2'd0:    rd_addr7 = (seg == '0) ? seg + NP_W'(1) : seg - NP_W'(1);
      2'd1:    rd_addr7 = seg;
      2'd2:    rd_addr7 = seg + NP_W'(1);
      default: rd_addr7 = (seg == n_m2) ? seg : seg + NP_W'(2);
    endcase
  end

  assign wr_en   = accept && (req_type == REQ_WRITE) && (32'(point_index) < MAX_POINTS);
  assign wr_wide = {{AW{1'b0}}, point_index};
  assign rd_en   = (state == S_READ) && !cnt[2];
  assign rd_wide = {{AW{1'b0}}, rd_addr7};
  assign cnt_m1  = cnt - 3'd1;

  assign eval_start = (state == S_START);
  assign out_free   = !result_valid || result_ready;

  crl_table #(
    .DEPTH(MAX_POINTS),
    .AW(AW)
  ) u_table (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_wide[AW-1:0]),
    .wr_data(point_value),
    .rd_en(rd_en),
    .rd_addr(rd_wide[AW-1:0]),
    .rd_data(rd_data)
  );

  crl_eval u_eval (
    .clk(clk),
    .rst(rst),
    .start(eval_start),
    .frac(frac),
    .pts(pts),
    .done(eval_done),
    .result(eval_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= '0;
    end else if (cfg_write_en) begin
      num_points <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= 3'd0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && req_type == REQ_QUERY) begin
            state <= (n_eff < NP_W'(2)) ? S_OUT : S_SEG;
          end
        end
        S_SEG: begin
          cnt   <= 3'd0;
          state <= S_READ;
        end
        S_READ: begin
          cnt <= cnt + 3'd1;
          if (cnt[2]) begin
            state <= S_START;
          end
        end
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (eval_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scaled   <= scaled_next;
      zero_res <= (n_eff < NP_W'(2));
    end
    // position one lands past the last segment: fold back with full fraction
    if (state == S_SEG) begin
      if (seg_hi >= {1'b0, n_m1}) begin
        seg  <= n_m2;
        frac <= FRAC_ONE;
      end else begin
        seg  <= seg_hi[NP_W-1:0];
        frac <= {1'b0, scaled[FRAC_W-1:0]};
      end
    end
    if (state == S_READ && cnt != 3'd0) begin
      pts[cnt_m1[1:0]] <= rd_data;
    end
    if (state == S_OUT && out_free) begin
      curve_value <= zero_res ? '0 : eval_result;
    end
  end

`ifndef SYNTH
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    eval_done |-> state == S_WAIT)
    else $error("evaluator finished outside the wait state");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && !cnt[2]) |-> rd_addr7 < n_eff)
    else $error("table read beyond the points in use");

  a_seg_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && cnt == 3'd0) |-> (seg <= n_m2 && frac <= FRAC_ONE))
    else $error("segment or fraction out of range");

  a_short_table: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_QUERY && n_eff < NP_W'(2)) |=> (state == S_OUT && zero_res))
    else $error("query on a short table did not go straight to output");
`endif

endmodule
